[rtl/pett_pkg.sv]
// Shared types and codes for the periodic event timer table.
// Holds the slot entry layout, function and status codes and sizing constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pett_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int MAX_OUT   = 8;
  localparam int CNT_W     = $clog2(MAX_OUT + 1);

  localparam logic [1:0] FN_TICK    = 2'd0;
  localparam logic [1:0] FN_ADD     = 2'd1;
  localparam logic [1:0] FN_DELETE  = 2'd2;
  localparam logic [1:0] FN_SERVICE = 2'd3;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_FIRED    = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
  } entry_t;

endpackage

`default_nettype wire

[rtl/periodic_event_timer_table.sv]
// Top level of the periodic event timer table: command sequencer and slot walk.
// Depends on pett_pkg and pett_mem.
//
// Usage: present a command on the in_ ports and raise start; it is taken at a
// rising edge where start is high and busy is low. Each result appears on the
// out_ ports for one cycle with out_valid high; out_last marks the final result
// of a command. The receiver cannot stall, so results are never held.
// Command handling:
//   delete, or add with a zero tag: result in the cycle after the transfer, busy
//   stays low, so one command per cycle.
//   add: walks the occupied flags one slot a cycle until it finds a free slot.
//   tick and service: walk every slot through the slot store, one slot a cycle,
//   reading each slot (registered read data) and writing back the ones that change,
//   then a flush state before busy drops; service results stream out during the walk.
// Occupied flags live in flip-flops and gate the store's contents, so reset
// empties the table at once with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module periodic_event_timer_table #(
  parameter int SLOTS = pett_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [2:0]  in_slot,
  input  wire logic [7:0]  in_event_tag,
  input  wire logic [15:0] in_delay_ticks,
  input  wire logic [15:0] in_period_ticks,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [2:0]       out_result_slot,
  output logic [7:0]       out_fired_tag,
  output logic             out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ADD   = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [1:0]               func_r, func_nxt;
  logic [7:0]               tag_r, tag_nxt;
  logic [15:0]              dly_r, dly_nxt;
  logic [15:0]              per_r, per_nxt;
  logic [SLOTS-1:0]         used_r, used_nxt;
  logic [IW-1:0]            ra_r, ra_nxt;
  logic                     issue_r, issue_nxt;
  logic                     dv_r, dv_nxt;
  logic [IW-1:0]            di_r, di_nxt;
  logic                     bufv_r, bufv_nxt;
  logic [IW-1:0]            bufi_r, bufi_nxt;
  logic [7:0]               buft_r, buft_nxt;
  logic [pett_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  logic       ov_r, ov_nxt;
  logic [1:0] ost_r, ost_nxt;
  logic [2:0] osl_r, osl_nxt;
  logic [7:0] otag_r, otag_nxt;
  logic       olast_r, olast_nxt;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  pett_pkg::entry_t mem_wdata;
  logic             mem_ren;
  pett_pkg::entry_t mem_rdata;

  logic             cur_used;
  logic [7:0]       cur_pend;
  logic [IW-1:0]    del_idx;
  logic             accept;

  pett_mem #(
    .DEPTH(SLOTS),
    .AW   (IW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .ren  (mem_ren),
    .raddr(ra_r),
    .rdata(mem_rdata)
  );

  function automatic logic [2:0] slot3(input logic [IW-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[2:0];
  endfunction

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign mem_ren = (state_r == S_WALK) && issue_r;
  assign cur_used = used_r[di_r];
  assign cur_pend = cur_used ? mem_rdata.pending : 8'd0;
  assign del_idx  = IW'(in_slot);

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    tag_nxt   = tag_r;
    dly_nxt   = dly_r;
    per_nxt   = per_r;
    used_nxt  = used_r;
    ra_nxt    = ra_r;
    issue_nxt = issue_r;
    dv_nxt    = 1'b0;
    di_nxt    = ra_r;
    bufv_nxt  = bufv_r;
    bufi_nxt  = bufi_r;
    buft_nxt  = buft_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    osl_nxt   = osl_r;
    otag_nxt  = otag_r;
    olast_nxt = olast_r;
    mem_we    = 1'b0;
    mem_waddr = ra_r;
    mem_wdata = mem_rdata;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt = in_func;
          tag_nxt  = in_event_tag;
          dly_nxt  = in_delay_ticks;
          per_nxt  = in_period_ticks;
          ra_nxt   = '0;
          case (in_func)
            pett_pkg::FN_DELETE: begin
              if (32'(in_slot) < SLOTS) begin
                used_nxt[del_idx] = 1'b0;
              end
              ov_nxt    = 1'b1;
              ost_nxt   = pett_pkg::ST_DONE;
              osl_nxt   = in_slot;
              otag_nxt  = 8'd0;
              olast_nxt = 1'b1;
            end
            pett_pkg::FN_ADD: begin
              if (in_event_tag == 8'd0) begin
                ov_nxt    = 1'b1;
                ost_nxt   = pett_pkg::ST_REJECTED;
                osl_nxt   = 3'd0;
                otag_nxt  = 8'd0;
                olast_nxt = 1'b1;
              end else begin
                state_nxt = S_ADD;
              end
            end
            default: begin
              state_nxt = S_WALK;
              issue_nxt = 1'b1;
              bufv_nxt  = 1'b0;
              cnt_nxt   = '0;
            end
          endcase
        end
      end

      S_ADD: begin
        if (!used_r[ra_r]) begin
          used_nxt[ra_r]    = 1'b1;
          mem_we            = 1'b1;
          mem_wdata.tag     = tag_r;
          mem_wdata.delay   = dly_r;
          mem_wdata.period  = per_r;
          mem_wdata.pending = 8'd0;
          ov_nxt    = 1'b1;
          ost_nxt   = pett_pkg::ST_DONE;
          osl_nxt   = slot3(ra_r);
          otag_nxt  = tag_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (ra_r == LAST_IDX) begin
          ov_nxt    = 1'b1;
          ost_nxt   = pett_pkg::ST_REJECTED;
          osl_nxt   = 3'd0;
          otag_nxt  = 8'd0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ra_nxt = ra_r + 1'b1;
        end
      end

      S_WALK: begin
        // issue reads one slot a cycle
        if (issue_r) begin
          dv_nxt = 1'b1;
          di_nxt = ra_r;
          if (ra_r == LAST_IDX) begin
            issue_nxt = 1'b0;
          end else begin
            ra_nxt = ra_r + 1'b1;
          end
        end
        // modify and write back the slot whose data has arrived
        if (dv_r) begin
          mem_waddr = di_r;
          if (func_r == pett_pkg::FN_TICK) begin
            if (cur_used) begin
              mem_we = 1'b1;
              if (mem_rdata.delay == 16'd0) begin
                if (mem_rdata.pending != 8'hFF) begin
                  mem_wdata.pending = mem_rdata.pending + 8'd1;
                end
                if (mem_rdata.period != 16'd0) begin
                  mem_wdata.delay = mem_rdata.period;
                end
              end else begin
                mem_wdata.delay = mem_rdata.delay - 16'd1;
              end
            end
          end else if (cur_pend != 8'd0 && 32'(cnt_r) < pett_pkg::MAX_OUT) begin
            mem_we            = 1'b1;
            mem_wdata.pending = cur_pend - 8'd1;
            if (mem_rdata.period == 16'd0) begin
              used_nxt[di_r] = 1'b0;
            end
            if (bufv_r) begin
              ov_nxt    = 1'b1;
              ost_nxt   = pett_pkg::ST_FIRED;
              osl_nxt   = slot3(bufi_r);
              otag_nxt  = buft_r;
              olast_nxt = 1'b0;
            end
            bufv_nxt = 1'b1;
            bufi_nxt = di_r;
            buft_nxt = mem_rdata.tag;
            cnt_nxt  = cnt_r + 1'b1;
          end
          if (di_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        state_nxt = S_IDLE;
        if (func_r == pett_pkg::FN_TICK) begin
          ost_nxt  = pett_pkg::ST_DONE;
          osl_nxt  = 3'd0;
          otag_nxt = 8'd0;
        end else if (bufv_r) begin
          ost_nxt  = pett_pkg::ST_FIRED;
          osl_nxt  = slot3(bufi_r);
          otag_nxt = buft_r;
        end else begin
          ost_nxt  = pett_pkg::ST_NONE;
          osl_nxt  = 3'd0;
          otag_nxt = 8'd0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      issue_r <= 1'b0;
      dv_r    <= 1'b0;
      bufv_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      issue_r <= issue_nxt;
      dv_r    <= dv_nxt;
      bufv_r  <= bufv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    tag_r   <= tag_nxt;
    dly_r   <= dly_nxt;
    per_r   <= per_nxt;
    ra_r    <= ra_nxt;
    di_r    <= di_nxt;
    bufi_r  <= bufi_nxt;
    buft_r  <= buft_nxt;
    cnt_r   <= cnt_nxt;
    ost_r   <= ost_nxt;
    osl_r   <= osl_nxt;
    otag_r  <= otag_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_result_slot = osl_r;
  assign out_fired_tag   = otag_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire

[rtl/pett_mem.sv]
// Slot store: one write port, one read port with registered read data.
// Depends on pett_pkg for the entry layout.
`timescale 1ns / 1ps
`default_nettype none

module pett_mem #(
  parameter int DEPTH = pett_pkg::SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire pett_pkg::entry_t wdata,
  input  wire logic             ren,
  input  wire logic [AW-1:0]    raddr,
  output pett_pkg::entry_t      rdata
);

  pett_pkg::entry_t mem [DEPTH];
  pett_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[verif/pett_checker.sv]
// Scoreboard for the periodic event timer table: watches command and result transfers.
// Keeps its own copy of the slot table and compares every result with the oldest one awaited.
// Depends on pett_pkg.
`timescale 1ns / 1ps

module pett_checker import pett_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_func,
  input  logic [2:0]  in_slot,
  input  logic [7:0]  in_event_tag,
  input  logic [15:0] in_delay_ticks,
  input  logic [15:0] in_period_ticks,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [2:0]  out_result_slot,
  input  logic [7:0]  out_fired_tag,
  input  logic        out_last,
  output int          mismatch_count,
  output int          reports_due
);

  localparam int SLOTS = SLOTS_DEF;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    logic [7:0] tag;
    logic       last;
  } report_t;

  report_t     report_q[$];
  report_t     awaited;
  logic        occupied  [SLOTS];
  logic [7:0]  tag_of    [SLOTS];
  logic [15:0] countdown [SLOTS];
  logic [15:0] reload    [SLOTS];
  logic [7:0]  runs      [SLOTS];
  int          fails = 0;

  initial begin
    mismatch_count = 0;
    reports_due    = 0;
  end

  function automatic report_t make_report(logic [1:0] status, logic [2:0] slot,
                                          logic [7:0] tag, logic last);
    report_t r;
    r.status = status;
    r.slot   = slot;
    r.tag    = tag;
    r.last   = last;
    return r;
  endfunction

  task automatic clear_slot(input int s);
    occupied[s]  = 1'b0;
    tag_of[s]    = 8'd0;
    countdown[s] = 16'd0;
    reload[s]    = 16'd0;
    runs[s]      = 8'd0;
  endtask

  task automatic step_timer_table(input logic [1:0] fn, input logic [2:0] idx,
                                  input logic [7:0] tg, input logic [15:0] dly,
                                  input logic [15:0] per);
    int      i;
    int      fired;
    bit      placed;
    bit      held_valid;
    report_t held;
    fired      = 0;
    placed     = 1'b0;
    held_valid = 1'b0;
    held       = '0;
    case (fn)
      FN_TICK: begin
        for (i = 0; i < SLOTS; i++) begin
          if (occupied[i]) begin
            if (countdown[i] == 16'd0) begin
              if (runs[i] != 8'hFF) runs[i] = runs[i] + 8'd1;
              if (reload[i] != 16'd0) countdown[i] = reload[i];
            end else begin
              countdown[i] = countdown[i] - 16'd1;
            end
          end
        end
        report_q.push_back(make_report(ST_DONE, 3'd0, 8'd0, 1'b1));
      end
      FN_ADD: begin
        if (tg != 8'd0) begin
          for (i = 0; i < SLOTS; i++) begin
            if (!placed && !occupied[i]) begin
              occupied[i]  = 1'b1;
              tag_of[i]    = tg;
              countdown[i] = dly;
              reload[i]    = per;
              runs[i]      = 8'd0;
              placed       = 1'b1;
              report_q.push_back(make_report(ST_DONE, i[2:0], tg, 1'b1));
            end
          end
        end
        if (!placed) report_q.push_back(make_report(ST_REJECTED, 3'd0, 8'd0, 1'b1));
      end
      FN_DELETE: begin
        if (int'(idx) < SLOTS) clear_slot(int'(idx));
        report_q.push_back(make_report(ST_DONE, idx, 8'd0, 1'b1));
      end
      default: begin
        for (i = 0; i < SLOTS && fired < MAX_OUT; i++) begin
          if (runs[i] != 8'd0) begin
            if (held_valid) report_q.push_back(held);
            held       = make_report(ST_FIRED, i[2:0], tag_of[i], 1'b0);
            held_valid = 1'b1;
            fired++;
            runs[i] = runs[i] - 8'd1;
            if (reload[i] == 16'd0) clear_slot(i);
          end
        end
        if (held_valid) begin
          held.last = 1'b1;
          report_q.push_back(held);
        end else begin
          report_q.push_back(make_report(ST_NONE, 3'd0, 8'd0, 1'b1));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) clear_slot(s);
      report_q.delete();
    end else begin
      if (start && !busy) begin
        step_timer_table(in_func, in_slot, in_event_tag, in_delay_ticks, in_period_ticks);
      end
      if (out_valid) begin
        if (report_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got status %0d slot %0d tag %0h last %0d",
                   $time, out_status, out_result_slot, out_fired_tag, out_last);
        end else begin
          awaited = report_q.pop_front();
          if (awaited.status !== out_status || awaited.slot !== out_result_slot ||
              awaited.tag !== out_fired_tag || awaited.last !== out_last) begin
            fails++;
            $display("%0t: mismatch, expected status %0d slot %0d tag %0h last %0d, got status %0d slot %0d tag %0h last %0d",
                     $time, awaited.status, awaited.slot, awaited.tag, awaited.last,
                     out_status, out_result_slot, out_fired_tag, out_last);
          end
        end
      end
    end
    mismatch_count <= fails;
    reports_due    <= report_q.size();
  end

endmodule

[verif/tb.sv]
// Top of the timer table testbench: clock, reset, command stimulus and the verdict.
// Depends on pett_pkg, periodic_event_timer_table and pett_checker.
`timescale 1ns / 1ps

module tb;
  import pett_pkg::*;

  localparam int LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic [1:0]  in_func;
  logic [2:0]  in_slot;
  logic [7:0]  in_event_tag;
  logic [15:0] in_delay_ticks;
  logic [15:0] in_period_ticks;
  logic        busy;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [2:0]  out_result_slot;
  logic [7:0]  out_fired_tag;
  logic        out_last;
  int          mismatch_count;
  int          reports_due;
  int          cycles = 0;

  periodic_event_timer_table u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_slot         (in_slot),
    .in_event_tag    (in_event_tag),
    .in_delay_ticks  (in_delay_ticks),
    .in_period_ticks (in_period_ticks),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_slot (out_result_slot),
    .out_fired_tag   (out_fired_tag),
    .out_last        (out_last)
  );

  pett_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_slot         (in_slot),
    .in_event_tag    (in_event_tag),
    .in_delay_ticks  (in_delay_ticks),
    .in_period_ticks (in_period_ticks),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_slot (out_result_slot),
    .out_fired_tag   (out_fired_tag),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .reports_due     (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // hold the command until the transfer edge
  task automatic issue(input logic [1:0] fn, input logic [2:0] idx, input logic [7:0] tg,
                       input logic [15:0] dly, input logic [15:0] per);
    in_func         <= fn;
    in_slot         <= idx;
    in_event_tag    <= tg;
    in_delay_ticks  <= dly;
    in_period_ticks <= per;
    start           <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  initial begin
    int          k;
    int          j;
    int          pick;
    logic [1:0]  fn;
    logic [7:0]  tg;
    logic [15:0] dly;
    logic [15:0] per;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = FN_TICK;
    in_slot         = 3'd0;
    in_event_tag    = 8'd0;
    in_delay_ticks  = 16'd0;
    in_period_ticks = 16'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(FN_SERVICE, 3'd0, 8'd0, 16'd0, 16'd0);
    issue(FN_TICK, 3'd7, 8'hFF, 16'hFFFF, 16'hFFFF);
    issue(FN_ADD, 3'd0, 8'd0, 16'd1, 16'd1);
    issue(FN_ADD, 3'd0, 8'hFF, 16'd0, 16'd0);
    issue(FN_ADD, 3'd0, 8'd1, 16'hFFFF, 16'hFFFF);
    issue(FN_ADD, 3'd0, 8'h5A, 16'd1, 16'd2);
    for (j = 3; j < 8; j++) issue(FN_ADD, 3'd0, 8'(17 * j), 16'(j & 1), 16'(j - 3));
    issue(FN_ADD, 3'd0, 8'h42, 16'd0, 16'd0);
    issue(FN_DELETE, 3'd3, 8'd0, 16'd0, 16'd0);
    issue(FN_DELETE, 3'd3, 8'd0, 16'd0, 16'd0);
    issue(FN_ADD, 3'd0, 8'hA5, 16'd0, 16'd1);
    issue(FN_TICK, 3'd0, 8'd0, 16'd0, 16'd0);
    issue(FN_TICK, 3'd0, 8'd0, 16'd0, 16'd0);
    issue(FN_SERVICE, 3'd0, 8'd0, 16'd0, 16'd0);
    issue(FN_SERVICE, 3'd0, 8'd0, 16'd0, 16'd0);
    issue(FN_TICK, 3'd0, 8'd0, 16'd0, 16'd0);
    issue(FN_SERVICE, 3'd0, 8'd0, 16'd0, 16'd0);
    for (j = 0; j < 8; j++) issue(FN_DELETE, 3'(j), 8'd0, 16'd0, 16'd0);
    drain();

    for (k = 0; k < 130; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) fn = FN_ADD;
      else if (pick < 60) fn = FN_TICK;
      else if (pick < 85) fn = FN_SERVICE;
      else fn = FN_DELETE;
      tg  = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      dly = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0, 1:    per = 16'd0;
        7:       per = 16'($urandom);
        default: per = 16'($urandom_range(1, 4));
      endcase
      issue(fn, 3'($urandom_range(0, 7)), tg, dly, per);
      if (k == 65) drain();
      else if (k < 105 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 18));
    end

    drain();
    repeat (3 * SLOTS_DEF) @(posedge clk);
    if (mismatch_count == 0 && reports_due == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pett_pkg.sv
rtl/pett_mem.sv
rtl/periodic_event_timer_table.sv
verif/pett_checker.sv
verif/tb.sv
